// ===== src/hwlc_pkg.sv =====
// Shared types, constants and table helpers for the windowed chirp generator.
package hwlc_pkg;

    // Default sizes handed to the top level parameters
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int LENGTH_BITS_DEF     = 16;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_INCREMENT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INCREMENT_STEP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_STEP       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHIRP_LENGTH      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE         = 3'd4;

    localparam int ACC_W    = 32;
    localparam int CLEN_W   = 16;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam logic [AMP_W-1:0] AMP_RESET = 15'd32767;

    // Q30 coefficients of sin(pi/2 * u), odd powers 1 to 11
    localparam longint PC1  = 64'sd1686629713;
    localparam longint PC3  = -64'sd693598669;
    localparam longint PC5  = 64'sd85569306;
    localparam longint PC7  = -64'sd5026995;
    localparam longint PC9  = 64'sd172271;
    localparam longint PC11 = -64'sd3864;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // input request taken this cycle
        logic sin_rd;   // look up sine of the carrier phase
        logic cos_rd;   // keep sine, look up cosine of the window phase
        logic gain_en;  // envelope times amplitude
        logic prod_en;  // gain times sine
        logic out_en;   // round, load output register, advance accumulators
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic running;  // a chirp is in progress
        logic out_busy; // output register holds a result not taken this cycle
    } t_dp_status;

    // Sign-magnitude Q30 product truncated toward zero
    function automatic longint mul_q30(input longint a, input longint b);
        logic        neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] m;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        m   = (ua * ub) >> 30;
        return neg ? -signed'(m) : signed'(m);
    endfunction

    // Q15 first-quadrant sine at entry r of a table with 2^bits entries per cycle
    function automatic logic [AMP_W-1:0] quarter_sine(input int r, input int bits);
        longint u;
        longint z;
        longint p;
        longint s;
        longint q;
        u = longint'(r) <<< (32 - bits);
        z = mul_q30(u, u);
        p = PC11;
        p = PC9 + mul_q30(p, z);
        p = PC7 + mul_q30(p, z);
        p = PC5 + mul_q30(p, z);
        p = PC3 + mul_q30(p, z);
        p = PC1 + mul_q30(p, z);
        s = mul_q30(p, u);
        if (s < 0) begin
            s = 0;
        end
        q = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (q > 32767) begin
            q = 32767;
        end
        return AMP_W'(q);
    endfunction

endpackage

// ===== src/hwlc_ctrl.sv =====
// Sequencing state machine for the windowed chirp generator.
module hwlc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  hwlc_pkg::t_dp_status  i_status,
    output hwlc_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SIN  = 6'b000010,
        S_COS  = 6'b000100,
        S_GAIN = 6'b001000,
        S_PROD = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SIN;
                end
            end
            S_SIN: begin
                if (i_status.running) begin
                    o_cmd.sin_rd = 1'b1;
                    n_state      = S_COS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_COS: begin
                o_cmd.cos_rd = 1'b1;
                n_state      = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_en = 1'b1;
                n_state       = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_en = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted request always goes to the sine lookup
    a_accept_to_sin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_SIN)
        else $error("accepted request did not move to sine lookup");

    // The output stage holds while the result register is blocked
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_status.out_busy) |=> r_state == S_OUT)
        else $error("output stage left while result register blocked");

endmodule

// ===== src/hwlc_datapath.sv =====
// Accumulators, sine table, gain and rounding datapath with output register.
module hwlc_datapath #(
    parameter int SINE_TABLE_BITS = hwlc_pkg::SINE_TABLE_BITS_DEF,
    parameter int LENGTH_BITS     = hwlc_pkg::LENGTH_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [hwlc_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [hwlc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_start_req,
    input  hwlc_pkg::t_dp_cmd                     i_cmd,
    output hwlc_pkg::t_dp_status                  o_status,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [hwlc_pkg::SAMPLE_W-1:0]         m_axis_tdata,
    output logic                                  m_axis_tlast
);

    localparam int B       = SINE_TABLE_BITS;
    localparam int QUARTER = 2 ** (B - 2);
    localparam int ACC_W   = hwlc_pkg::ACC_W;
    localparam int AMP_W   = hwlc_pkg::AMP_W;
    localparam int SW      = hwlc_pkg::SAMPLE_W;

    localparam logic [B-2:0] QUARTER_A = (B - 1)'(QUARTER);
    localparam logic [B-1:0] QUARTER_K = B'(QUARTER);

    // Quarter-wave sine table, entries 0 to QUARTER inclusive
    typedef logic [AMP_W-1:0] t_qrom [QUARTER+1];

    function automatic t_qrom build_qrom();
        t_qrom rom_v;
        for (int i = 0; i <= QUARTER; i++) begin
            rom_v[i] = hwlc_pkg::quarter_sine(i, B);
        end
        return rom_v;
    endfunction

    localparam t_qrom QROM = build_qrom();

    // Configuration registers
    logic [ACC_W-1:0]            r_init_inc;
    logic [ACC_W-1:0]            r_inc_step;
    logic [ACC_W-1:0]            r_win_step;
    logic [hwlc_pkg::CLEN_W-1:0] r_chirp_length;
    logic [AMP_W-1:0]            r_amplitude;

    // Chirp state
    logic [LENGTH_BITS-1:0] r_index;
    logic [ACC_W-1:0]       r_phase_acc;
    logic [ACC_W-1:0]       r_phase_inc;
    logic [ACC_W-1:0]       r_win_phase;
    logic                   r_running;

    // Pipeline registers
    logic [AMP_W-1:0]     r_rom_mag;
    logic                 r_rom_neg;
    logic signed [SW-1:0] r_sin;
    logic [AMP_W-1:0]     r_gain;
    logic signed [31:0]   r_prod;

    // Output register
    logic          r_out_valid;
    logic [SW-1:0] r_out_sample;
    logic          r_out_last;

    logic [LENGTH_BITS-1:0] len;
    logic                   len_zero;
    logic                   len_one;
    logic                   is_last;
    logic [B-1:0]           rom_k;
    logic [B-2:0]           rom_r;
    logic [B-2:0]           rom_addr;
    logic signed [SW-1:0]   rom_val;
    logic signed [17:0]     env_diff;
    logic [15:0]            env;
    logic [31:0]            gain_full;
    logic [31:0]            prod_mag;
    logic [16:0]            y_mag;
    logic [SW-1:0]          y;

    assign len      = LENGTH_BITS'(r_chirp_length);
    assign len_zero = (len == LENGTH_BITS'(0));
    assign len_one  = (len == LENGTH_BITS'(1));
    assign is_last  = ({1'b0, r_index} + (LENGTH_BITS + 1)'(1)) >= {1'b0, len};

    // Table address: sine of carrier phase, or cosine as a quarter-cycle shift
    always_comb begin
        if (i_cmd.cos_rd) begin
            rom_k = r_win_phase[ACC_W-1 -: B] + QUARTER_K;
        end else begin
            rom_k = r_phase_acc[ACC_W-1 -: B];
        end
        rom_r    = {1'b0, rom_k[B-3:0]};
        rom_addr = rom_k[B-2] ? (QUARTER_A - rom_r) : rom_r;
    end

    assign rom_val = r_rom_neg ? -signed'({1'b0, r_rom_mag}) : signed'({1'b0, r_rom_mag});

    // Envelope from the cosine and the gain product
    always_comb begin
        env_diff = 18'sd32768 - 18'(rom_val);
        if (len_one) begin
            env = 16'h8000;
        end else begin
            env = env_diff[16:1];
        end
        gain_full = 32'(r_amplitude) * 32'(env) + 32'd16384;
    end

    // Round half away from zero and saturate
    always_comb begin
        prod_mag = r_prod[31] ? 32'(-r_prod) : 32'(r_prod);
        y_mag    = 17'((prod_mag + 32'd16384) >> 15);
        if (r_prod[31]) begin
            if (y_mag > 17'd32768) begin
                y = 16'h8000;
            end else begin
                y = 16'(-y_mag);
            end
        end else begin
            if (y_mag > 17'd32767) begin
                y = 16'h7fff;
            end else begin
                y = y_mag[SW-1:0];
            end
        end
    end

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_inc     <= '0;
            r_inc_step     <= '0;
            r_win_step     <= '0;
            r_chirp_length <= '0;
            r_amplitude    <= hwlc_pkg::AMP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hwlc_pkg::CFG_INITIAL_INCREMENT: r_init_inc     <= i_cfg_data;
                hwlc_pkg::CFG_INCREMENT_STEP:    r_inc_step     <= i_cfg_data;
                hwlc_pkg::CFG_WINDOW_STEP:       r_win_step     <= i_cfg_data;
                hwlc_pkg::CFG_CHIRP_LENGTH:      r_chirp_length <= i_cfg_data[hwlc_pkg::CLEN_W-1:0];
                hwlc_pkg::CFG_AMPLITUDE:         r_amplitude    <= i_cfg_data[AMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Chirp state: restart on a start request, advance when a sample is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_phase_acc <= '0;
            r_phase_inc <= '0;
            r_win_phase <= '0;
            r_running   <= 1'b0;
        end else if (i_cmd.accept && i_start_req) begin
            r_index     <= '0;
            r_phase_acc <= '0;
            r_phase_inc <= r_init_inc;
            r_win_phase <= '0;
            r_running   <= !len_zero;
        end else if (i_cmd.out_en) begin
            r_phase_acc <= r_phase_acc + r_phase_inc;
            r_phase_inc <= r_phase_inc + r_inc_step;
            r_win_phase <= r_win_phase + r_win_step;
            r_index     <= r_index + LENGTH_BITS'(1);
            if (is_last) begin
                r_running <= 1'b0;
            end
        end
    end

    // Table read and arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.sin_rd || i_cmd.cos_rd) begin
            r_rom_mag <= QROM[rom_addr];
            r_rom_neg <= rom_k[B-1];
        end
        if (i_cmd.cos_rd) begin
            r_sin <= rom_val;
        end
        if (i_cmd.gain_en) begin
            r_gain <= gain_full[AMP_W+14:15];
        end
        if (i_cmd.prod_en) begin
            r_prod <= signed'({1'b0, r_gain}) * r_sin;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_en) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_out_sample <= y;
            r_out_last   <= is_last;
        end
    end

    assign o_status.running  = r_running;
    assign o_status.out_busy = r_out_valid && !m_axis_tready;
    assign m_axis_tvalid     = r_out_valid;
    assign m_axis_tdata      = r_out_sample;
    assign m_axis_tlast      = r_out_last;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_en |-> !(r_out_valid && !m_axis_tready))
        else $error("result register overwritten while pending");

    // Table lookups only happen for a running chirp
    a_lookup_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sin_rd |-> r_running)
        else $error("sine lookup with no chirp running");

    // A chirp stops only on its final sample or a restart with zero length
    a_stop_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_running) |-> ($past(i_cmd.out_en && is_last)
                              || $past(i_cmd.accept && i_start_req)))
        else $error("chirp stopped without final sample or restart");

    // A new result appears only when the output stage issued one
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.out_en))
        else $error("result valid without output command");

endmodule

// ===== src/hann_windowed_linear_chirp_generator_core.sv =====
// Top level of the Hann-windowed linear chirp generator.
// Each request steps through accept, sine read, cosine read, gain multiply, product multiply and
//   output before the next is taken, set by the shared table port and the two multiply stages.
// A result is valid in the output register after the output step; a request that gives
//   no result returns to idle from the sine read step. A stalled output holds the output step.
// Reset: synchronous, active low; clears control, chirp state, configuration (amplitude 32767) and output valid.
module hann_windowed_linear_chirp_generator_core #(
    parameter int SINE_TABLE_BITS = hwlc_pkg::SINE_TABLE_BITS_DEF,
    parameter int LENGTH_BITS     = hwlc_pkg::LENGTH_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [hwlc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hwlc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [0] start_req, [7:1] zero
    // sample stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [15:0]                      m_axis_tdata,  // [15:0] sample
    output logic                             m_axis_tlast
);

    hwlc_pkg::t_dp_cmd    cmd;
    hwlc_pkg::t_dp_status status;

    // Sequencer
    hwlc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Datapath
    hwlc_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_req   (s_axis_tdata[0]),
        .i_cmd         (cmd),
        .o_status      (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
